@@ hdl/slb_pkg.sv @@
// Shared types, codes and constants of the status LED SOS and step blinker.
`timescale 1ns / 1ps

package slb_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_ON    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_STEP_OFF   = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOS_SHORT  = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOS_LONG   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOS_GAP    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOS_PAUSE  = 3'd5;

   // Reset values of the durations, ms
   localparam logic [15:0] STEP_ON_RESET   = 16'd130;
   localparam logic [15:0] STEP_OFF_RESET  = 16'd130;
   localparam logic [15:0] SOS_SHORT_RESET = 16'd150;
   localparam logic [15:0] SOS_LONG_RESET  = 16'd450;
   localparam logic [15:0] SOS_GAP_RESET   = 16'd150;
   localparam logic [15:0] SOS_PAUSE_RESET = 16'd800;

   // SOS loop shape
   localparam logic [3:0] SOS_PULSES     = 4'd9;
   localparam logic [3:0] SOS_LONG_FIRST = 4'd3;
   localparam logic [3:0] SOS_LONG_LAST  = 4'd5;

   // Power thresholds and blink counts
   localparam logic [7:0] PCT_FOUR  = 8'd100;
   localparam logic [7:0] PCT_THREE = 8'd75;
   localparam logic [7:0] PCT_TWO   = 8'd50;
   localparam logic [2:0] BLINKS_ONE   = 3'd1;
   localparam logic [2:0] BLINKS_TWO   = 3'd2;
   localparam logic [2:0] BLINKS_THREE = 3'd3;
   localparam logic [2:0] BLINKS_FOUR  = 3'd4;

   typedef enum logic [1:0] {
      MODE_BASE = 2'd0,
      MODE_STEP = 2'd1,
      MODE_SOS  = 2'd2
   } mode_type;

   typedef struct packed {
      logic [15:0] step_on_time;
      logic [15:0] step_off_time;
      logic [15:0] sos_short_time;
      logic [15:0] sos_long_time;
      logic [15:0] sos_gap_time;
      logic [15:0] sos_pause_time;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        base_level;
      logic        trip_level;
      logic        step_trigger;
      logic [7:0]  power_percent;
   } item_type;

endpackage

@@ hdl/slb_pattern.sv @@
// Pattern state and next-state logic: trip handling, step burst, SOS loop.
`timescale 1ns / 1ps

module slb_pattern (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  slb_pkg::item_type item,
   input  slb_pkg::cfg_type  cfg,
   output logic              led_on,
   output slb_pkg::mode_type mode
);
   import slb_pkg::*;

   logic        trip_seen_ff, trip_seen_in;
   logic [3:0]  sos_index_ff, sos_index_in;
   logic        sos_lit_ff, sos_lit_in;
   logic [31:0] sos_deadline_ff, sos_deadline_in;
   logic [2:0]  blinks_left_ff, blinks_left_in;
   logic        step_lit_ff, step_lit_in;
   logic [31:0] step_deadline_ff, step_deadline_in;
   logic        led_level_ff, led_level_in;

   // State after the trip change and trigger stages of the item
   logic [3:0]  sos_index_a;
   logic        sos_lit_a;
   logic [31:0] sos_deadline_a;
   logic [2:0]  blinks_a;
   logic        step_lit_a;
   logic [31:0] step_deadline_a;
   logic [2:0]  blink_count;
   logic        sos_wait;
   logic        step_wait;
   logic        sos_long;

   always_comb begin
      if (item.power_percent >= PCT_FOUR) begin
         blink_count = BLINKS_FOUR;
      end else if (item.power_percent >= PCT_THREE) begin
         blink_count = BLINKS_THREE;
      end else if (item.power_percent >= PCT_TWO) begin
         blink_count = BLINKS_TWO;
      end else begin
         blink_count = BLINKS_ONE;
      end
   end

   always_comb begin
      trip_seen_in = item.trip_level;
      if (item.trip_level != trip_seen_ff) begin
         sos_index_a    = '0;
         sos_lit_a      = 1'b0;
         sos_deadline_a = '0;
      end else begin
         sos_index_a    = sos_index_ff;
         sos_lit_a      = sos_lit_ff;
         sos_deadline_a = sos_deadline_ff;
      end

      if (item.step_trigger) begin
         blinks_a        = blink_count;
         step_lit_a      = 1'b0;
         step_deadline_a = '0;
      end else begin
         blinks_a        = blinks_left_ff;
         step_lit_a      = step_lit_ff;
         step_deadline_a = step_deadline_ff;
      end
   end

   // A deadline of zero means none is set, so the phase moves on at once.
   assign sos_wait  = (sos_deadline_a != '0) && (item.now_ms < sos_deadline_a);
   assign step_wait = (step_deadline_a != '0) && (item.now_ms < step_deadline_a);
   assign sos_long  = (sos_index_a >= SOS_LONG_FIRST) && (sos_index_a <= SOS_LONG_LAST);

   always_comb begin
      sos_index_in     = sos_index_a;
      sos_lit_in       = sos_lit_a;
      sos_deadline_in  = sos_deadline_a;
      blinks_left_in   = blinks_a;
      step_lit_in      = step_lit_a;
      step_deadline_in = step_deadline_a;
      led_level_in     = led_level_ff;
      mode             = MODE_BASE;

      if (item.trip_level) begin
         mode = MODE_SOS;
         if (!sos_wait) begin
            if (sos_index_a >= SOS_PULSES) begin
               sos_index_in    = '0;
               sos_lit_in      = 1'b0;
               led_level_in    = 1'b0;
               sos_deadline_in = item.now_ms + {16'd0, cfg.sos_pause_time};
            end else if (!sos_lit_a) begin
               sos_lit_in      = 1'b1;
               led_level_in    = 1'b1;
               sos_deadline_in = item.now_ms +
                  {16'd0, (sos_long ? cfg.sos_long_time : cfg.sos_short_time)};
            end else begin
               sos_lit_in      = 1'b0;
               led_level_in    = 1'b0;
               sos_deadline_in = item.now_ms + {16'd0, cfg.sos_gap_time};
               sos_index_in    = sos_index_a + 4'd1;
            end
         end
      end else if (blinks_a != '0) begin
         mode = MODE_STEP;
         if (!step_wait) begin
            if (!step_lit_a) begin
               step_lit_in      = 1'b1;
               led_level_in     = 1'b1;
               step_deadline_in = item.now_ms + {16'd0, cfg.step_on_time};
            end else begin
               step_lit_in      = 1'b0;
               led_level_in     = 1'b0;
               step_deadline_in = item.now_ms + {16'd0, cfg.step_off_time};
               blinks_left_in   = blinks_a - 3'd1;
            end
         end
      end else begin
         led_level_in = item.base_level;
      end
   end

   assign led_on = led_level_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         trip_seen_ff     <= 1'b0;
         sos_index_ff     <= '0;
         sos_lit_ff       <= 1'b0;
         sos_deadline_ff  <= '0;
         blinks_left_ff   <= '0;
         step_lit_ff      <= 1'b0;
         step_deadline_ff <= '0;
         led_level_ff     <= 1'b0;
      end else if (advance) begin
         trip_seen_ff     <= trip_seen_in;
         sos_index_ff     <= sos_index_in;
         sos_lit_ff       <= sos_lit_in;
         sos_deadline_ff  <= sos_deadline_in;
         blinks_left_ff   <= blinks_left_in;
         step_lit_ff      <= step_lit_in;
         step_deadline_ff <= step_deadline_in;
         led_level_ff     <= led_level_in;
      end
   end

endmodule

@@ hdl/status_led_sos_and_step_blinker_unit.sv @@
// Status LED blinker top level: input register, pattern logic, result register, CSRs.
// An item moves from the input register to the result register once that is free.
// Throughput: one item per cycle while rsp_ready is high; the input and result
// registers each pass one item a cycle, and the pattern state updates once per item.
// Reset is synchronous and active high; it clears the pattern state, empties both
// registers and returns all durations to their default values.
`timescale 1ns / 1ps

module status_led_sos_and_step_blinker_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_now_ms,
   input  logic        req_base_level,
   input  logic        req_trip_level,
   input  logic        req_step_trigger,
   input  logic [7:0]  req_power_percent,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_led_on,
   output logic [1:0]  rsp_pattern_mode,
   input  logic        csr_write,
   input  logic [slb_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0] csr_data
);
   import slb_pkg::*;

   cfg_type  cfg_ff;
   item_type item_ff;
   logic     item_valid_ff;
   logic     rsp_valid_ff;
   logic     rsp_led_on_ff;
   mode_type rsp_mode_ff;
   logic     out_free;
   logic     advance;
   logic     led_on_in;
   mode_type mode_in;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_on_time   <= STEP_ON_RESET;
         cfg_ff.step_off_time  <= STEP_OFF_RESET;
         cfg_ff.sos_short_time <= SOS_SHORT_RESET;
         cfg_ff.sos_long_time  <= SOS_LONG_RESET;
         cfg_ff.sos_gap_time   <= SOS_GAP_RESET;
         cfg_ff.sos_pause_time <= SOS_PAUSE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_STEP_ON:   cfg_ff.step_on_time   <= csr_data;
            CSR_STEP_OFF:  cfg_ff.step_off_time  <= csr_data;
            CSR_SOS_SHORT: cfg_ff.sos_short_time <= csr_data;
            CSR_SOS_LONG:  cfg_ff.sos_long_time  <= csr_data;
            CSR_SOS_GAP:   cfg_ff.sos_gap_time   <= csr_data;
            CSR_SOS_PAUSE: cfg_ff.sos_pause_time <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Input register: refills in the same cycle that its item moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_ready) begin
         item_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         item_ff.now_ms        <= req_now_ms;
         item_ff.base_level    <= req_base_level;
         item_ff.trip_level    <= req_trip_level;
         item_ff.step_trigger  <= req_step_trigger;
         item_ff.power_percent <= req_power_percent;
      end
   end

   slb_pattern u_pattern (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .led_on  (led_on_in),
      .mode    (mode_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
      if (advance) begin
         rsp_led_on_ff <= led_on_in;
         rsp_mode_ff   <= mode_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_led_on       = rsp_led_on_ff;
   assign rsp_pattern_mode = rsp_mode_ff;

endmodule
